>>> hw/rtl/crc16pf_pkg.sv
// ----------------------------------------------------------------------------
// crc16pf_pkg: shared type, constants and fold function of the CRC-16 framer
// Holds the CRC-16 polynomial, the per-byte fold function and the trailer
// state encoding.
// ----------------------------------------------------------------------------
package crc16pf_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CRC_W  = 16;

    localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
    localparam logic [CRC_W-1:0] CRC_INIT = 16'h0000;

    typedef enum logic [1:0] {
        ST_BODY,
        ST_CRC_HI,
        ST_CRC_LO
    } frame_state_t;

    // Fold one byte into the CRC, MSB first, no reflection.
    function automatic logic [CRC_W-1:0] crc_fold(
        input logic [CRC_W-1:0]  crc,
        input logic [BYTE_W-1:0] data
    );
        logic [CRC_W-1:0] acc;
        acc = crc ^ {data, {(CRC_W-BYTE_W){1'b0}}};
        for (int i = 0; i < BYTE_W; i++)
        begin
            if (acc[CRC_W-1])
            begin
                acc = {acc[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                acc = {acc[CRC_W-2:0], 1'b0};
            end
        end
        return acc;
    endfunction

endpackage

>>> hw/rtl/crc16_packet_framer.sv
// ----------------------------------------------------------------------------
// crc16_packet_framer: CRC-16 packet trailer generator
// Passes packet body bytes through and appends the CRC-16 high and low bytes
// after the byte flagged as the last of the packet.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one body byte per transfer in
//   data_byte, with last_byte set on the final byte of a packet. Output
//   channel (out_valid/out_ready) carries out_byte with is_checksum and
//   end_of_packet flags.
//   Every body byte passes unchanged into the output register. A byte
//   flagged last is followed by the CRC high byte and then the CRC low byte
//   (end_of_packet set). CRC-16: polynomial 0x1021, init 0, MSB first, no
//   final XOR; it restarts at zero for the next packet.
//   Throughput: one body byte per cycle while out_ready holds. A last byte
//   is followed by both CRC bytes, and the input is held off until they
//   are loaded; the output register is the single stage that sets this.
//   Reset clears the CRC, the trailer state and the output valid flag.
//   When the receiver stalls, the output register holds its byte and the
//   input is held off as long as that slot cannot drain.
// ----------------------------------------------------------------------------
module crc16_packet_framer
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       last_byte,

    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       is_checksum,
    output logic       end_of_packet
);

    // Running CRC and latched trailer value
    logic [crc16pf_pkg::CRC_W-1:0] crc_reg;
    logic [crc16pf_pkg::CRC_W-1:0] crc_next;
    logic [crc16pf_pkg::CRC_W-1:0] trail_reg;
    logic [crc16pf_pkg::CRC_W-1:0] trail_next;
    logic [crc16pf_pkg::CRC_W-1:0] crc_folded;

    // Trailer sequencer
    crc16pf_pkg::frame_state_t state_reg;
    crc16pf_pkg::frame_state_t state_next;

    // Output register
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [crc16pf_pkg::BYTE_W-1:0] out_byte_reg;
    logic [crc16pf_pkg::BYTE_W-1:0] out_byte_next;
    logic                           is_chk_reg;
    logic                           is_chk_next;
    logic                           eop_reg;
    logic                           eop_next;

    logic out_free;
    logic in_xfer;

    // The output slot can take a new byte when it is empty or draining now.
    assign out_free = !out_valid_reg || out_ready;
    // Take body bytes only while no trailer byte is waiting.
    assign in_ready = out_free && (state_reg == crc16pf_pkg::ST_BODY);
    assign in_xfer  = in_valid && in_ready;

    assign crc_folded = crc16pf_pkg::crc_fold(crc_reg, data_byte);

    // Next state of the trailer sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            crc16pf_pkg::ST_BODY:
            begin
                if (in_xfer && last_byte)
                begin
                    state_next = crc16pf_pkg::ST_CRC_HI;
                end
            end
            crc16pf_pkg::ST_CRC_HI:
            begin
                if (out_free)
                begin
                    state_next = crc16pf_pkg::ST_CRC_LO;
                end
            end
            crc16pf_pkg::ST_CRC_LO:
            begin
                if (out_free)
                begin
                    state_next = crc16pf_pkg::ST_BODY;
                end
            end
            default:
            begin
                state_next = crc16pf_pkg::ST_BODY;
            end
        endcase
    end

    // Datapath and output register loading
    always_comb
    begin
        crc_next       = crc_reg;
        trail_next     = trail_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        is_chk_next    = is_chk_reg;
        eop_next       = eop_reg;

        // Drop the byte once the receiver takes it.
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            crc16pf_pkg::ST_BODY:
            begin
                if (in_xfer)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = data_byte;
                    is_chk_next    = 1'b0;
                    eop_next       = 1'b0;
                    if (last_byte)
                    begin
                        // Latch the finished CRC and restart for the next packet.
                        trail_next = crc_folded;
                        crc_next   = crc16pf_pkg::CRC_INIT;
                    end
                    else
                    begin
                        crc_next = crc_folded;
                    end
                end
            end
            crc16pf_pkg::ST_CRC_HI:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = trail_reg[crc16pf_pkg::CRC_W-1:crc16pf_pkg::BYTE_W];
                    is_chk_next    = 1'b1;
                    eop_next       = 1'b0;
                end
            end
            crc16pf_pkg::ST_CRC_LO:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = trail_reg[crc16pf_pkg::BYTE_W-1:0];
                    is_chk_next    = 1'b1;
                    eop_next       = 1'b1;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= crc16pf_pkg::ST_BODY;
            crc_reg       <= crc16pf_pkg::CRC_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        trail_reg    <= trail_next;
        out_byte_reg <= out_byte_next;
        is_chk_reg   <= is_chk_next;
        eop_reg      <= eop_next;
    end

    assign out_valid     = out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign is_checksum   = is_chk_reg;
    assign end_of_packet = eop_reg;

`ifndef SYNTHESIS
    // A last byte transfer starts the trailer.
    a_last_starts_trailer: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && last_byte |=> state_reg == crc16pf_pkg::ST_CRC_HI)
        else $error("trailer not started after last byte");

    // While the trailer is pending the output slot is occupied.
    a_trailer_holds_output: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != crc16pf_pkg::ST_BODY |-> out_valid_reg)
        else $error("output slot empty while trailer pending");

    // The CRC has already restarted while the trailer drains.
    a_crc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != crc16pf_pkg::ST_BODY |-> crc_reg == crc16pf_pkg::CRC_INIT)
        else $error("CRC not cleared during trailer");

    // End of packet only on a checksum byte.
    a_eop_is_checksum: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_packet |-> is_checksum)
        else $error("end_of_packet on a body byte");
`endif

endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the CRC-16 packet framer
// Sends directed and random packets through the input channel and tracks each
// transfer in a scoreboard. The scoreboard keeps its own running CRC-16 and
// works out the echoed bytes and the two trailer bytes of each packet. Both
// channels idle and stall at random, and every output transfer is checked
// field by field against the oldest owed byte.
// ----------------------------------------------------------------------------
module tb_top;

    // Run limit in clock cycles, several times the slowest legal run.
    localparam int unsigned RUN_LIMIT_CYCLES = 400_000;
    localparam int unsigned CLK_PERIOD       = 8;
    localparam int unsigned RANDOM_ITEMS     = 180;
    // Cycles to let pass once nothing is owed, to catch stray outputs.
    localparam int unsigned DRAIN_CYCLES     = 20;

    // One byte the framer owes on its output channel.
    typedef struct packed {
        logic [crc16pf_pkg::BYTE_W-1:0] tx_byte;
        logic                           chk;
        logic                           eop;
    } framed_byte_t;

    // ------------------------------------------------------------------------
    // Scoreboard: own running CRC and a queue of owed output bytes.
    // ------------------------------------------------------------------------
    class frame_tracker;

        logic [crc16pf_pkg::CRC_W-1:0] crc_acc;
        framed_byte_t                  owed_bytes[$];
        int unsigned                   mismatches;

        function new();
            crc_acc    = crc16pf_pkg::CRC_INIT;
            mismatches = 0;
        endfunction

        // Shift one data bit at a time into the CRC, MSB first.
        function logic [crc16pf_pkg::CRC_W-1:0] crc_step(
            logic [crc16pf_pkg::CRC_W-1:0]  crc,
            logic [crc16pf_pkg::BYTE_W-1:0] data);
            logic [crc16pf_pkg::CRC_W-1:0] acc;
            logic                          fb;
            acc = crc;
            for (int b = crc16pf_pkg::BYTE_W - 1; b >= 0; b--)
            begin
                fb  = acc[crc16pf_pkg::CRC_W-1] ^ data[b];
                acc = {acc[crc16pf_pkg::CRC_W-2:0], 1'b0}
                      ^ (fb ? crc16pf_pkg::CRC_POLY : '0);
            end
            return acc;
        endfunction

        task report(string what, int unsigned got, int unsigned want);
            mismatches++;
            $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h",
                     $time, what, got, want);
        endtask

        // Note one accepted input transfer and queue what it owes.
        function void note_transfer(logic [crc16pf_pkg::BYTE_W-1:0] data, logic last);
            framed_byte_t fb;
            crc_acc = crc_step(crc_acc, data);
            fb = '{tx_byte: data, chk: 1'b0, eop: 1'b0};
            owed_bytes.push_back(fb);
            if (last)
            begin
                fb = '{tx_byte: crc_acc[15:8], chk: 1'b1, eop: 1'b0};
                owed_bytes.push_back(fb);
                fb = '{tx_byte: crc_acc[7:0], chk: 1'b1, eop: 1'b1};
                owed_bytes.push_back(fb);
                crc_acc = crc16pf_pkg::CRC_INIT;
            end
        endfunction

        // Compare one output transfer with the oldest owed byte.
        task check_result(logic [crc16pf_pkg::BYTE_W-1:0] got_byte, logic got_chk,
                          logic got_eop);
            framed_byte_t want;
            if (owed_bytes.size() == 0)
            begin
                report("unexpected output transfer", got_byte, 0);
            end
            else
            begin
                want = owed_bytes.pop_front();
                if (got_byte !== want.tx_byte)
                    report("out_byte", got_byte, want.tx_byte);
                if (got_chk !== want.chk)
                    report("is_checksum", got_chk, want.chk);
                if (got_eop !== want.eop)
                    report("end_of_packet", got_eop, want.eop);
            end
        endtask

        function int unsigned pending();
            return owed_bytes.size();
        endfunction

    endclass

    // ------------------------------------------------------------------------
    // Signals and block instance
    // ------------------------------------------------------------------------
    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_ready;
    logic [crc16pf_pkg::BYTE_W-1:0] data_byte;
    logic                           last_byte;
    logic                           out_valid;
    logic                           out_ready;
    logic [crc16pf_pkg::BYTE_W-1:0] out_byte;
    logic                           is_checksum;
    logic                           end_of_packet;

    // Idling switches; turned off per packet to get dense stretches.
    bit                tx_idle_on;
    bit                rx_stall_on;
    int unsigned       items_sent;

    frame_tracker      tracker;

    crc16_packet_framer dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .last_byte     (last_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .is_checksum   (is_checksum),
        .end_of_packet (end_of_packet)
    );

    // ------------------------------------------------------------------------
    // Clock, reset and run limit
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Hard stop: a hung handshake lands here.
    initial
    begin
        #(RUN_LIMIT_CYCLES * CLK_PERIOD);
        $display("FAILURE");
        $finish;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int unsigned pick_gap(bit enable);
        int unsigned roll;
        if (!enable)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: both channels are sampled at the rising edge, before any
    // nonblocking update of that edge lands, so the order of processes in a
    // time step does not matter. Note the input transfer first; its output
    // can appear no earlier than the next edge.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                tracker.note_transfer(data_byte, last_byte);
            if (out_valid && out_ready)
                tracker.check_result(out_byte, is_checksum, end_of_packet);
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: hold ready high for a random run, then stall for a random
    // gap. Drop ready only when the gap is nonzero, so ready never gets two
    // updates in one time step.
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned stall;
        out_ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            stall = pick_gap(rx_stall_on);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender tasks
    // ------------------------------------------------------------------------

    // Offer one body byte and hold it until the transfer happens. The task
    // returns at the accepting edge; a following call with no gap keeps
    // valid high with a single update.
    task automatic send_byte(logic [crc16pf_pkg::BYTE_W-1:0] data, logic last);
        int unsigned gap;
        gap = pick_gap(tx_idle_on);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= data;
        last_byte <= last;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
    endtask

    // Send one packet of random body bytes; the last one carries the flag.
    task automatic send_packet(int unsigned len);
        for (int unsigned i = 0; i < len; i++)
            send_byte(8'($urandom_range(0, 255)), i == len - 1);
    endtask

    // Drop valid and hold off until every owed byte has left the block.
    task automatic drain_outputs();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        string       check_str;
        int unsigned len;
        bit          paused;

        tracker     = new();
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        data_byte   = '0;
        last_byte   = 1'b0;
        tx_idle_on  = 1'b0;
        rx_stall_on = 1'b0;
        items_sent  = 0;
        paused      = 1'b0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Start with single-byte packets back to back, at
        // the byte extremes, so the trailer hold-off is hit right away.
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h80, 1'b1);
        send_byte(8'h01, 1'b1);

        // Standard check string; its trailer must be 0x31C3.
        check_str = "123456789";
        for (int i = 0; i < check_str.len(); i++)
            send_byte(check_str[i], i == check_str.len() - 1);

        // Bytes of all ones and all zeros inside a longer packet.
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b1);

        // A packet under full idling on both sides.
        tx_idle_on  = 1'b1;
        rx_stall_on = 1'b1;
        send_byte(8'h7F, 1'b0);
        send_byte(8'hFE, 1'b1);

        // Random part: packets mostly short, a few long, each with its own
        // idling mix so dense stretches alternate with gappy ones.
        while (items_sent < RANDOM_ITEMS)
        begin
            tx_idle_on  = ($urandom_range(0, 3) != 0);
            rx_stall_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) == 0)
                len = $urandom_range(13, 40);
            else
                len = $urandom_range(1, 12);
            send_packet(len);

            // Halfway through, let the block run dry before going on.
            if (!paused && items_sent >= RANDOM_ITEMS / 2)
            begin
                drain_outputs();
                paused = 1'b1;
            end
        end

        // Wind down: stop offering, wait for every owed byte, then give the
        // block a few more cycles to show anything it should not send.
        drain_outputs();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.pending() != 0)
            tracker.report("owed bytes never sent", 0, tracker.pending());

        if (tracker.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
